>>> rtl/core/rdq_pkg.sv
// shared constants, operation codes and ring helpers for the reversible deque
package rdq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 10;
    localparam int CMP_W   = (FILL_W > POS_W) ? FILL_W : POS_W;

    localparam logic [ADDR_W-1:0] DEPTH_M1  = ADDR_W'(DEPTH - 1);
    localparam logic [WORD_W-1:0] DATA_NONE = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_READ       = 3'd4,
        KIND_REVERSE    = 3'd5
    } kind_t;

    // (a + b) mod DEPTH for a, b below DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/core/rdq_ram.sv
// generic single-write single-read ram with registered read data
module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/reversible_deque.sv
// reversible deque top level: ring pointers, request decode and result register
//
// bounded double-ended queue of signed 32-bit words kept in a ring memory
// request channel s_*: s_kind selects push back, push front, pop back,
//   pop front, read by index or reverse; s_value is the word to push and
//   s_position the index to read, counted from the logical front
// result channel m_*: one result per request, m_data (popped or read word,
//   -1 when there is none), m_ok and m_fill (words stored afterwards)
// pointers and count update at the edge that accepts a request, and the
//   memory read or write is issued in the same cycle
// the registered memory read completes at the accepting edge, and the
//   result then moves from the pending stage into the output register
//   once that register is free
// s_ready is low after each acceptance while the request sits in the
//   pending stage, so a new request waits until the previous one leaves it
// reset empties the queue and restores normal orientation; the memory
//   contents are left as they are and never read before being written
// when the receiver stalls the result waits in the output register while
//   one more request is still accepted; that request then holds in the
//   pending stage and s_ready stays low until the output register frees
module reversible_deque
    import rdq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [KIND_W-1:0]        s_kind,
    input  logic signed [WORD_W-1:0] s_value,
    input  logic [POS_W-1:0]         s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_data,
    output logic                     m_ok,
    output logic [FILL_W-1:0]        m_fill
);

    // ring state
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] count_reg, count_next;
    logic              flipped_reg, flipped_next;

    // pending stage: request whose memory read is in flight
    logic              pend_reg, pend_next;
    logic              pend_ram_reg, pend_ram_next;
    logic              pend_ok_reg, pend_ok_next;
    logic [FILL_W-1:0] pend_fill_reg, pend_fill_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_data_reg, m_data_next;
    logic              m_ok_reg, m_ok_next;
    logic [FILL_W-1:0] m_fill_reg, m_fill_next;

    // memory port signals
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic              accept, move;
    logic              full, empty, pos_ok;
    logic [FILL_W-1:0] count_m1;
    logic [ADDR_W-1:0] head_dec, head_inc;
    logic [ADDR_W-1:0] addr_high_push, addr_high_pop, addr_read;
    logic [CMP_W-1:0]  pos_ext, count_ext, read_off;
    logic              push_low, pop_low;

    // a new request only when no memory read is outstanding, so a write
    // always lands before any later read of the same entry
    assign s_ready = !pend_reg;
    assign accept  = s_valid && s_ready;
    // pending result moves to the output register when that is free
    assign move    = pend_reg && (!m_valid_reg || m_ready);

    assign full     = (count_reg == FILL_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - FILL_W'(1);

    assign pos_ext   = CMP_W'(s_position);
    assign count_ext = CMP_W'(count_reg);
    assign pos_ok    = (pos_ext < count_ext);

    // physical ends of the stored run
    assign head_dec       = (head_reg == '0) ? DEPTH_M1 : head_reg - ADDR_W'(1);
    assign head_inc       = (head_reg == DEPTH_M1) ? '0 : head_reg + ADDR_W'(1);
    assign addr_high_push = ring_add(head_reg, count_reg[ADDR_W-1:0]);
    assign addr_high_pop  = ring_add(head_reg, count_m1[ADDR_W-1:0]);

    // logical index counts from the high end while flipped
    assign read_off  = flipped_reg ? (count_ext - CMP_W'(1) - pos_ext) : pos_ext;
    assign addr_read = ring_add(head_reg, read_off[ADDR_W-1:0]);

    // front maps to the low end unless flipped
    assign push_low = (s_kind == KIND_PUSH_FRONT) != flipped_reg;
    assign pop_low  = (s_kind == KIND_POP_FRONT) != flipped_reg;

    // request decode and ring update
    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        flipped_next   = flipped_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_high_push;
        rd_en          = 1'b0;
        rd_addr        = addr_read;
        pend_ram_next  = 1'b0;
        pend_ok_next   = 1'b0;
        if (accept) begin
            unique case (s_kind)
                KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                    // a push onto a full queue is dropped
                    if (!full) begin
                        wr_en        = 1'b1;
                        count_next   = count_reg + FILL_W'(1);
                        pend_ok_next = 1'b1;
                        if (push_low) begin
                            wr_addr   = head_dec;
                            head_next = head_dec;
                        end else begin
                            wr_addr = addr_high_push;
                        end
                    end
                end
                KIND_POP_BACK, KIND_POP_FRONT: begin
                    if (!empty) begin
                        rd_en         = 1'b1;
                        count_next    = count_m1;
                        pend_ram_next = 1'b1;
                        pend_ok_next  = 1'b1;
                        if (pop_low) begin
                            rd_addr   = head_reg;
                            head_next = head_inc;
                        end else begin
                            rd_addr = addr_high_pop;
                        end
                    end
                end
                KIND_READ: begin
                    if (pos_ok) begin
                        rd_en         = 1'b1;
                        rd_addr       = addr_read;
                        pend_ram_next = 1'b1;
                        pend_ok_next  = 1'b1;
                    end
                end
                KIND_REVERSE: begin
                    // orientation flip only, no data moves
                    flipped_next = !flipped_reg;
                    pend_ok_next = 1'b1;
                end
                default: begin
                    // unused codes leave the state alone and fail
                end
            endcase
        end
    end

    // pending stage and output register
    always_comb begin
        pend_next      = pend_reg;
        pend_fill_next = pend_fill_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_ok_next      = m_ok_reg;
        m_fill_next    = m_fill_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (move) begin
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
            m_data_next  = pend_ram_reg ? rd_data : DATA_NONE;
            m_ok_next    = pend_ok_reg;
            m_fill_next  = pend_fill_reg;
        end
        if (accept) begin
            pend_next      = 1'b1;
            pend_fill_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            flipped_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            flipped_reg <= flipped_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_ram_reg <= pend_ram_next;
            pend_ok_reg  <= pend_ok_next;
        end
        pend_fill_reg <= pend_fill_next;
        m_data_reg    <= m_data_next;
        m_ok_reg      <= m_ok_next;
        m_fill_reg    <= m_fill_next;
    end

    // ring store; read data holds until the next read is issued
    rdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_ok    = m_ok_reg;
    assign m_fill  = m_fill_reg;

    // count never passes the ring size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FILL_W'(DEPTH))
        else $error("count exceeds depth");

    // ring state only changes on an accepted request
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(head_reg) && $stable(count_reg) && $stable(flipped_reg))
        else $error("ring state changed without a request");

    // an accepted request always occupies the pending stage next cycle
    a_pend_set: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> pend_reg && !s_ready)
        else $error("accepted request not pending");

    // failed or data-less results carry all ones
    a_fail_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ok_reg |-> m_data_reg == DATA_NONE)
        else $error("failed result carries data");

endmodule
